### src/ifst_pkg.sv
package ifst_pkg;

	localparam logic [7:0] FLAG_BYTE     = 8'h7E;
	localparam logic [7:0] ESC_BYTE      = 8'h7D;
	localparam logic [7:0] ESC_MASK      = 8'h20;
	localparam logic [7:0] ADDRESS_RESET = 8'h03;
	localparam int         CTRL_SHIFT    = 6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_frame;
	} in_item_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_last;
		logic       frame_end;
	} out_item_t;

	typedef struct packed {
		logic       hdr;
		logic [7:0] addr;
		logic       seq;
		logic [7:0] data;
		logic       last;
		logic [7:0] parity;
	} job_t;

	typedef enum logic [3:0] {
		PH_FLAG_OPEN,
		PH_ADDR,
		PH_CTRL,
		PH_CHECK,
		PH_DATA,
		PH_DATA_ESC,
		PH_PAR,
		PH_PAR_ESC,
		PH_FLAG_CLOSE
	} phase_t;

	function automatic logic needs_esc(input logic [7:0] b);
		return (b == FLAG_BYTE) || (b == ESC_BYTE);
	endfunction

	function automatic logic [7:0] ctrl_byte(input logic seq);
		return 8'(seq) << CTRL_SHIFT;
	endfunction

endpackage

### src/ifst_queue.sv
module ifst_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ifst_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output ifst_pkg::job_t pop_data,
	output logic           not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	ifst_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/ifst_front.sv
module ifst_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  ifst_pkg::in_item_t in_data,
	input  logic               q_full,
	output logic               q_push,
	output ifst_pkg::job_t     q_job
);

	logic [7:0] address_q;
	logic       seq_q;
	logic [7:0] parity_q;
	logic       inside_q;
	logic [7:0] parity_cur;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign q_push    = in_valid && in_ready;

	assign parity_cur = inside_q ? parity_q : 8'h00;

	always_comb begin
		q_job.hdr    = !inside_q;
		q_job.addr   = address_q;
		q_job.seq    = seq_q;
		q_job.data   = in_data.data_byte;
		q_job.last   = in_data.last_of_frame;
		q_job.parity = parity_cur ^ in_data.data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= ifst_pkg::ADDRESS_RESET;
			seq_q     <= 1'b0;
			parity_q  <= '0;
			inside_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				address_q <= cfg_data;
			end
			if (q_push) begin
				if (!inside_q) begin
					seq_q <= !seq_q;
				end
				inside_q <= !in_data.last_of_frame;
				parity_q <= in_data.last_of_frame ? 8'h00 : q_job.parity;
			end
		end
	end

endmodule

### src/ifst_back.sv
module ifst_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  ifst_pkg::job_t      q_job,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output ifst_pkg::out_item_t out_data
);

	ifst_pkg::phase_t    phase_q;
	ifst_pkg::phase_t    nxt_phase;
	ifst_pkg::phase_t    start_phase;
	ifst_pkg::job_t      job_q;
	ifst_pkg::out_item_t out_q;
	logic                busy_q;
	logic                out_valid_q;
	logic                load;
	logic                done;
	logic [7:0]          byte_val;
	logic                fe_val;
	logic [7:0]          ctrl;

	assign load        = busy_q && (!out_valid_q || out_ready);
	assign q_pop       = q_valid && (!busy_q || (load && done));
	assign start_phase = q_job.hdr ? ifst_pkg::PH_FLAG_OPEN : ifst_pkg::PH_DATA;
	assign ctrl        = ifst_pkg::ctrl_byte(job_q.seq);

	always_comb begin
		nxt_phase = phase_q;
		done      = 1'b0;
		unique case (phase_q)
			ifst_pkg::PH_FLAG_OPEN: nxt_phase = ifst_pkg::PH_ADDR;
			ifst_pkg::PH_ADDR:      nxt_phase = ifst_pkg::PH_CTRL;
			ifst_pkg::PH_CTRL:      nxt_phase = ifst_pkg::PH_CHECK;
			ifst_pkg::PH_CHECK:     nxt_phase = ifst_pkg::PH_DATA;
			ifst_pkg::PH_DATA: begin
				if (ifst_pkg::needs_esc(job_q.data)) begin
					nxt_phase = ifst_pkg::PH_DATA_ESC;
				end else if (job_q.last) begin
					nxt_phase = ifst_pkg::PH_PAR;
				end else begin
					done = 1'b1;
				end
			end
			ifst_pkg::PH_DATA_ESC: begin
				if (job_q.last) begin
					nxt_phase = ifst_pkg::PH_PAR;
				end else begin
					done = 1'b1;
				end
			end
			ifst_pkg::PH_PAR: begin
				nxt_phase = ifst_pkg::needs_esc(job_q.parity) ? ifst_pkg::PH_PAR_ESC
				                                              : ifst_pkg::PH_FLAG_CLOSE;
			end
			ifst_pkg::PH_PAR_ESC:    nxt_phase = ifst_pkg::PH_FLAG_CLOSE;
			ifst_pkg::PH_FLAG_CLOSE: done = 1'b1;
			default:                 done = 1'b1;
		endcase
	end

	always_comb begin
		byte_val = ifst_pkg::FLAG_BYTE;
		fe_val   = 1'b0;
		unique case (phase_q)
			ifst_pkg::PH_FLAG_OPEN: byte_val = ifst_pkg::FLAG_BYTE;
			ifst_pkg::PH_ADDR:      byte_val = job_q.addr;
			ifst_pkg::PH_CTRL:      byte_val = ctrl;
			ifst_pkg::PH_CHECK:     byte_val = job_q.addr ^ ctrl;
			ifst_pkg::PH_DATA: begin
				byte_val = ifst_pkg::needs_esc(job_q.data) ? ifst_pkg::ESC_BYTE : job_q.data;
			end
			ifst_pkg::PH_DATA_ESC:  byte_val = job_q.data ^ ifst_pkg::ESC_MASK;
			ifst_pkg::PH_PAR: begin
				byte_val = ifst_pkg::needs_esc(job_q.parity) ? ifst_pkg::ESC_BYTE
				                                             : job_q.parity;
			end
			ifst_pkg::PH_PAR_ESC:   byte_val = job_q.parity ^ ifst_pkg::ESC_MASK;
			ifst_pkg::PH_FLAG_CLOSE: begin
				byte_val = ifst_pkg::FLAG_BYTE;
				fe_val   = 1'b1;
			end
			default: byte_val = ifst_pkg::FLAG_BYTE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (load) begin
			out_q.line_byte <= byte_val;
			out_q.run_last  <= done;
			out_q.frame_end <= fe_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ifst_pkg::PH_FLAG_OPEN;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= start_phase;
				busy_q  <= 1'b1;
			end else if (load && done) begin
				busy_q <= 1'b0;
			end else if (load) begin
				phase_q <= nxt_phase;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_end |-> out_q.run_last && out_q.line_byte == ifst_pkg::FLAG_BYTE)
		else $error("closing flag not marked as last byte of its item");

	a_hdr_order: assert property (@(posedge clk) disable iff (!arst_n)
		load && !q_pop && phase_q == ifst_pkg::PH_FLAG_OPEN |=> phase_q == ifst_pkg::PH_ADDR)
		else $error("header sequence broken");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	a_esc_follows: assert property (@(posedge clk) disable iff (!arst_n)
		load && !done && byte_val == ifst_pkg::ESC_BYTE
		&& (phase_q == ifst_pkg::PH_DATA || phase_q == ifst_pkg::PH_PAR)
		|=> busy_q && (phase_q == ifst_pkg::PH_DATA_ESC || phase_q == ifst_pkg::PH_PAR_ESC))
		else $error("escape byte not followed by escaped value");
`endif

endmodule

### src/info_frame_stuffing_transmitter_core.sv
// Information-frame transmitter: payload bytes in, stuffed line bytes out, one line
// byte per clock at most. The input side takes one byte per cycle while the job queue
// (QUEUE_DEPTH entries) has room; the output serializer then turns each byte into
// line bytes: a plain byte gives one, an escaped byte two, a frame start four more
// and a frame end two or three more (parity, possible escape, closing flag). The
// serializer sets the sustained rate. Address writes on the cfg channel are always
// accepted and apply from the next frame header.
module info_frame_stuffing_transmitter_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  ifst_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ifst_pkg::out_item_t out_data
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_valid;
	ifst_pkg::job_t push_job;
	ifst_pkg::job_t pop_job;

	ifst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	ifst_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_job),
		.not_empty (q_valid)
	);

	ifst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (pop_job),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### bench/tb_info_frame_stuffing_transmitter_core.sv
`timescale 1ns / 100ps

module tb_info_frame_stuffing_transmitter_core;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [7:0]          cfg_data;
	logic                in_valid;
	logic                in_ready;
	ifst_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	ifst_pkg::out_item_t out_data;

	int errors = 0;
	bit quiet = 1'b0;
	int hold_req = 0;
	int hold_left = 0;
	int stall_left = 0;

	// predicted transmitter state
	logic [7:0]          tx_address = ifst_pkg::ADDRESS_RESET;
	logic                tx_seq = 1'b0;
	logic [7:0]          tx_parity = 8'h00;
	logic                tx_open = 1'b0;
	ifst_pkg::out_item_t pending_line_bytes[$];

	info_frame_stuffing_transmitter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#(20_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(12, 40);
	endfunction

	function automatic int pick_gap();
		if (quiet || $urandom_range(0, 99) < 60)
			return 0;
		return pick_len();
	endfunction

	function automatic logic [7:0] pick_data();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return ifst_pkg::FLAG_BYTE;
		else if (r < 24)
			return ifst_pkg::ESC_BYTE;
		else if (r < 30) begin
			case ($urandom_range(0, 3))
				0: return 8'h00;
				1: return 8'hFF;
				2: return ifst_pkg::FLAG_BYTE ^ ifst_pkg::ESC_MASK;
				default: return ifst_pkg::ESC_BYTE ^ ifst_pkg::ESC_MASK;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_address();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return ifst_pkg::FLAG_BYTE;
			3: return ifst_pkg::ESC_BYTE;
			4: return ifst_pkg::ADDRESS_RESET;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_line(input logic [7:0] b, input logic closing);
		ifst_pkg::out_item_t item;
		item.line_byte = b;
		item.run_last = 1'b0;
		item.frame_end = closing;
		pending_line_bytes.push_back(item);
	endfunction

	function automatic void add_stuffed(input logic [7:0] b);
		if (b == ifst_pkg::FLAG_BYTE || b == ifst_pkg::ESC_BYTE) begin
			add_line(ifst_pkg::ESC_BYTE, 1'b0);
			add_line(b ^ ifst_pkg::ESC_MASK, 1'b0);
		end else begin
			add_line(b, 1'b0);
		end
	endfunction

	function automatic void predict_line_bytes(input ifst_pkg::in_item_t item);
		logic [7:0] ctrl;
		if (!tx_open) begin
			ctrl = {7'd0, tx_seq} << ifst_pkg::CTRL_SHIFT;
			add_line(ifst_pkg::FLAG_BYTE, 1'b0);
			add_line(tx_address, 1'b0);
			add_line(ctrl, 1'b0);
			add_line(tx_address ^ ctrl, 1'b0);
			tx_seq = ~tx_seq;
			tx_parity = 8'h00;
			tx_open = 1'b1;
		end
		tx_parity = tx_parity ^ item.data_byte;
		add_stuffed(item.data_byte);
		if (item.last_of_frame) begin
			add_stuffed(tx_parity);
			add_line(ifst_pkg::FLAG_BYTE, 1'b1);
			tx_parity = 8'h00;
			tx_open = 1'b0;
		end
		pending_line_bytes[pending_line_bytes.size() - 1].run_last = 1'b1;
	endfunction

	function automatic void check_line_byte(input ifst_pkg::out_item_t got);
		ifst_pkg::out_item_t want;
		if (pending_line_bytes.size() == 0) begin
			errors++;
			$display("%0t: unexpected line byte, expected none, actual %h/%b/%b", $time,
				got.line_byte, got.run_last, got.frame_end);
		end else begin
			want = pending_line_bytes.pop_front();
			if (got.line_byte !== want.line_byte) begin
				errors++;
				$display("%0t: line_byte expected %h actual %h", $time,
					want.line_byte, got.line_byte);
			end
			if (got.run_last !== want.run_last) begin
				errors++;
				$display("%0t: run_last expected %b actual %b", $time,
					want.run_last, got.run_last);
			end
			if (got.frame_end !== want.frame_end) begin
				errors++;
				$display("%0t: frame_end expected %b actual %b", $time,
					want.frame_end, got.frame_end);
			end
		end
	endfunction

	// predicts on each input transfer and checks each output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tx_address = cfg_data;
			if (in_valid && in_ready)
				predict_line_bytes(in_data);
			if (out_valid && out_ready)
				check_line_byte(out_data);
		end
	end

	// line side: random stalls, plus long hold-off on request
	always begin
		@(negedge clk);
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 99) < 25) begin
			out_ready = 1'b0;
			stall_left = pick_len() - 1;
		end else begin
			out_ready = 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_data.data_byte = b;
		in_data.last_of_frame = last;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_frame(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_line_bytes.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_address(input logic [7:0] value);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_stuffing();
		send_frame('{8'h00});
		send_frame('{8'hFF});
		send_frame('{ifst_pkg::FLAG_BYTE});
		send_frame('{ifst_pkg::ESC_BYTE});
		// parity comes out as a flag, then as an escape
		send_frame('{8'h12, 8'h6C});
		send_frame('{ifst_pkg::FLAG_BYTE, 8'h03});
		send_frame('{8'h5E, 8'h5D, 8'h20, ifst_pkg::ESC_BYTE, ifst_pkg::FLAG_BYTE, 8'h01});
		send_frame('{8'hAA, 8'h55});
	endtask

	task automatic test_address();
		write_address(8'h00);
		send_frame('{8'h11});
		write_address(8'hFF);
		send_frame('{8'h22, 8'h33});
		write_address(ifst_pkg::FLAG_BYTE);
		send_frame('{ifst_pkg::FLAG_BYTE});
		write_address(ifst_pkg::ESC_BYTE);
		send_frame('{8'h44});
		// change inside an open frame applies at the next header only
		send_byte(8'h55, 1'b0);
		write_address(8'hA5);
		send_byte(8'h66, 1'b1);
		send_frame('{8'h77});
		write_address(ifst_pkg::ADDRESS_RESET);
	endtask

	task automatic test_backpressure();
		wait_idle();
		quiet = 1'b1;
		hold_req = 150;
		for (int i = 0; i < 24; i++)
			send_byte(pick_data(), i % 5 == 4);
		wait_idle();
		quiet = 1'b0;
	endtask

	task automatic test_random();
		int items;
		int len;
		items = 0;
		while (items < 300) begin
			if ($urandom_range(0, 9) == 0)
				write_address(pick_address());
			quiet = ($urandom_range(0, 4) == 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				send_byte(pick_data(), i == len - 1);
				items++;
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 8'h00;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_stuffing();
		test_address();
		test_backpressure();
		test_random();

		wait_idle();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
